// File: rtl/assert_macros.svh
// Assertion macros for the monitor RTL.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property every clock, quiet during reset.
`define RPDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define RPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RPDM_ASSERT(lbl, prop, msg)
`define RPDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/rpdm_pkg.sv
// Shared types, constants and helpers of the relative pose displacement monitor.
// No dependencies.
`timescale 1ns / 1ps
package rpdm_pkg;

    localparam int POS_W        = 32;
    localparam int ANG_W        = 16;
    localparam int OUT_W        = 32;
    localparam int TRIG_FRAC    = 14;
    localparam int TRIG_W       = TRIG_FRAC + 2;
    localparam int LTOL_W       = 31;
    localparam int ATOL_W       = 15;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int ITER_W       = 5;
    localparam int CORDIC_FRAC  = 30;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0]   TRIG_ONE  = 16'sd16384;

    localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1};

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_REBASE = 2'd1,
        CMD_GOAL   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DISP_KEEP    = 2'd0,
        DISP_COMPUTE = 2'd1,
        DISP_CLEAR   = 2'd2
    } disp_op_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [ANG_W-1:0] yaw_angle;
    } item_t;

    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                     busy;
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
    } cordic_rsp_t;

    localparam int ADDR_W = 3;
    localparam logic REG_LIN_TOL = 1'b0;
    localparam logic REG_ANG_TOL = 1'b1;
    localparam logic [LTOL_W-1:0] LTOL_RESET = 31'd3277;
    localparam logic [ATOL_W-1:0] ATOL_RESET = 15'd182;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] abs32(input logic signed [OUT_W-1:0] v);
        logic signed [OUT_W:0] w;
        w = v;
        if (w < 0)
            w = -w;
        return w[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/rpdm_front.sv
// Front end: accepts input words, classifies the command, holds a two-entry queue.
// Depends on rpdm_pkg.
`timescale 1ns / 1ps
module rpdm_front
    import rpdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pos_x, pos_y, yaw_angle
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      in_item;

    always_comb
    begin
        in_item.pos_x     = s_axis_tdata[31:0];
        in_item.pos_y     = s_axis_tdata[63:32];
        in_item.yaw_angle = s_axis_tdata[79:64];
        unique case (s_axis_tuser)
            2'd0:    in_item.cmd = CMD_SAMPLE;
            2'd1:    in_item.cmd = CMD_REBASE;
            2'd2:    in_item.cmd = CMD_GOAL;
            default: in_item.cmd = CMD_NONE;
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// File: rtl/rpdm_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a final rounding step.
// Depends on rpdm_pkg.
`timescale 1ns / 1ps
module rpdm_cordic
    import rpdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;
    logic                       flip_reg, flip_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [TRIG_W-1:0]   cos_reg, cos_next, sin_reg, sin_next;
    logic [31:0]                z32;
    logic signed [CORDIC_W-1:0] xs, ys, arc, xf, yf, xr, yr;

    function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [CORDIC_W-1:0] v);
        if (v > CORDIC_W'(TRIG_ONE))
            return TRIG_ONE;
        else if (v < -CORDIC_W'(TRIG_ONE))
            return -TRIG_ONE;
        else
            return v[TRIG_W-1:0];
    endfunction

    always_comb
    begin
        z32  = {req.angle, {(32-ANG_W){1'b0}}};
        xs   = x_reg >>> iter_reg;
        ys   = y_reg >>> iter_reg;
        arc  = (iter_reg < ITER_W'(CORDIC_STEPS)) ? CORDIC_W'(ARC_TABLE[iter_reg]) : '0;
        xf   = flip_reg ? -x_reg : x_reg;
        yf   = flip_reg ? -y_reg : y_reg;
        xr   = (xf + CORDIC_W'(1 << (CORDIC_FRAC - TRIG_FRAC - 1))) >>> (CORDIC_FRAC - TRIG_FRAC);
        yr   = (yf + CORDIC_W'(1 << (CORDIC_FRAC - TRIG_FRAC - 1))) >>> (CORDIC_FRAC - TRIG_FRAC);

        busy_next = busy_reg;
        iter_next = iter_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;

        if (req.start)
        begin
            // fold the second and third quadrants by a half turn
            flip_next = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = CORDIC_W'($signed({z32[31] ^ flip_next, z32[30:0]}));
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (iter_reg == ITER_W'(CORDIC_STEPS))
            begin
                cos_next  = clamp_one(xr);
                sin_next  = clamp_one(yr);
                busy_next = 1'b0;
            end
            else
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - arc;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + arc;
                end
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            cos_reg  <= TRIG_ONE;
            sin_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.cosine = cos_reg;
    assign rsp.sine   = sin_reg;

endmodule

// File: rtl/rpdm_back.sv
// Back end: pose state update and products, then displacement, errors and flags.
// Depends on rpdm_pkg and assert_macros.svh; drives the CORDIC request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpdm_back
    import rpdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output cordic_req_t        cordic_req,
    input  cordic_rsp_t        cordic_rsp,
    input  logic [LTOL_W-1:0]  lin_tol,
    input  logic [ATOL_W-1:0]  ang_tol,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [199:0]       m_axis_tdata
);

    localparam int PROD_W = POS_W + 1 + TRIG_W;

    // architectural state
    logic signed [POS_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [ANG_W-1:0] cur_yaw_reg, cur_yaw_next, prev_yaw_reg, prev_yaw_next;
    logic signed [POS_W-1:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic signed [OUT_W-1:0] heading_reg, heading_next;
    logic signed [POS_W-1:0] tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic signed [ANG_W-1:0] tgt_yaw_reg, tgt_yaw_next;
    logic                    seen_reg, seen_next, armed_reg, armed_next;
    logic signed [POS_W-1:0] disp_x_reg, disp_x_next, disp_y_reg, disp_y_next;

    // second stage
    logic                    b_valid_reg, b_valid_next;
    disp_op_t                b_op_reg, b_op_next;
    logic signed [PROD_W-1:0] xc_reg, xc_next, ys_reg, ys_next;
    logic signed [PROD_W-1:0] yc_reg, yc_next, xs_reg, xs_next;
    logic signed [OUT_W-1:0] b_head_reg;
    logic signed [POS_W-1:0] b_tx_reg, b_ty_reg;
    logic signed [ANG_W-1:0] b_ta_reg;
    logic                    b_armed_reg, b_seen_reg;

    // output word
    logic                    out_valid_reg, out_valid_next;
    logic [199:0]            out_data_reg, out_data_next;

    logic                    out_free, b_free, fire, first;
    logic signed [POS_W:0]   dx, dy;
    logic signed [ANG_W-1:0] step;
    logic signed [63:0]      sum_x, sum_y, hsum, ex64, ey64, ea64;
    logic signed [OUT_W-1:0] ex, ey, ea;
    logic                    xw, yw, aw;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign b_free   = !b_valid_reg || out_free;
    assign fire     = q_valid && b_free && !cordic_rsp.busy;
    assign q_pop    = fire;
    assign first    = !seen_reg;

    // stage A: update pose state and form the four rotation products
    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_yaw_next  = cur_yaw_reg;
        prev_yaw_next = prev_yaw_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        heading_next  = heading_reg;
        tgt_x_next    = tgt_x_reg;
        tgt_y_next    = tgt_y_reg;
        tgt_yaw_next  = tgt_yaw_reg;
        seen_next     = seen_reg;
        armed_next    = armed_reg;
        b_op_next     = DISP_KEEP;
        cordic_req.start = 1'b0;
        cordic_req.angle = cur_yaw_reg;
        dx   = '0;
        dy   = '0;
        step = '0;
        hsum = '0;

        if (fire)
        begin
            unique case (q_item.cmd)
                CMD_SAMPLE:
                begin
                    cur_x_next   = q_item.pos_x;
                    cur_y_next   = q_item.pos_y;
                    cur_yaw_next = q_item.yaw_angle;
                    if (first)
                    begin
                        // first sample rebases onto itself
                        seen_next        = 1'b1;
                        armed_next       = 1'b0;
                        start_x_next     = q_item.pos_x;
                        start_y_next     = q_item.pos_y;
                        cordic_req.start = 1'b1;
                        cordic_req.angle = q_item.yaw_angle;
                        step = '0;
                        hsum = '0;
                    end
                    else
                    begin
                        step = q_item.yaw_angle - prev_yaw_reg;
                        hsum = heading_reg;
                    end
                    dx = q_item.pos_x - start_x_next;
                    dy = q_item.pos_y - start_y_next;
                    hsum = hsum + step;
                    heading_next  = sat32(hsum);
                    prev_yaw_next = q_item.yaw_angle;
                    b_op_next     = DISP_COMPUTE;
                end
                CMD_REBASE:
                begin
                    armed_next       = 1'b0;
                    start_x_next     = cur_x_reg;
                    start_y_next     = cur_y_reg;
                    heading_next     = '0;
                    cordic_req.start = 1'b1;
                    b_op_next        = DISP_CLEAR;
                end
                CMD_GOAL:
                begin
                    tgt_x_next   = q_item.pos_x;
                    tgt_y_next   = q_item.pos_y;
                    tgt_yaw_next = q_item.yaw_angle;
                    armed_next   = 1'b1;
                end
                default:
                begin
                    b_op_next = DISP_KEEP;
                end
            endcase
        end

        xc_next = dx * cordic_rsp.cosine;
        ys_next = dy * cordic_rsp.sine;
        yc_next = dy * cordic_rsp.cosine;
        xs_next = dx * cordic_rsp.sine;
        b_valid_next = fire || (b_valid_reg && !out_free);
    end

    // stage B: round and saturate (or clear or hold) the displacement, then errors and flags
    always_comb
    begin
        sum_x = xc_reg + ys_reg + 64'sd8192;
        sum_y = yc_reg - xs_reg + 64'sd8192;
        disp_x_next = disp_x_reg;
        disp_y_next = disp_y_reg;
        case (b_op_reg)
            DISP_COMPUTE:
            begin
                disp_x_next = sat32(sum_x >>> TRIG_FRAC);
                disp_y_next = sat32(sum_y >>> TRIG_FRAC);
            end
            DISP_CLEAR:
            begin
                disp_x_next = '0;
                disp_y_next = '0;
            end
            default:
            begin
                disp_x_next = disp_x_reg;
                disp_y_next = disp_y_reg;
            end
        endcase
        ex64 = b_tx_reg - disp_x_next;
        ey64 = b_ty_reg - disp_y_next;
        ea64 = b_ta_reg - b_head_reg;
        ex   = sat32(ex64);
        ey   = sat32(ey64);
        ea   = sat32(ea64);
        xw   = b_armed_reg && (abs32(ex) <= {1'b0, lin_tol});
        yw   = b_armed_reg && (abs32(ey) <= {1'b0, lin_tol});
        aw   = b_armed_reg && (abs32(ea) <= {{(OUT_W-ATOL_W){1'b0}}, ang_tol});

        out_data_next = {2'b00, b_armed_reg, b_seen_reg, xw && yw && aw, aw, yw, xw,
                         ea, ey, ex, b_head_reg, disp_y_next, disp_x_next};
        out_valid_next = (b_valid_reg && out_free) || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_yaw_reg   <= '0;
            prev_yaw_reg  <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            heading_reg   <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            tgt_yaw_reg   <= '0;
            seen_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            disp_x_reg    <= '0;
            disp_y_reg    <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cur_yaw_reg   <= cur_yaw_next;
            prev_yaw_reg  <= prev_yaw_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            heading_reg   <= heading_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            tgt_yaw_reg   <= tgt_yaw_next;
            seen_reg      <= seen_next;
            armed_reg     <= armed_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (b_valid_reg && out_free)
            begin
                disp_x_reg <= disp_x_next;
                disp_y_reg <= disp_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            b_op_reg    <= b_op_next;
            xc_reg      <= xc_next;
            ys_reg      <= ys_next;
            yc_reg      <= yc_next;
            xs_reg      <= xs_next;
            b_head_reg  <= heading_next;
            b_tx_reg    <= tgt_x_next;
            b_ty_reg    <= tgt_y_next;
            b_ta_reg    <= tgt_yaw_next;
            b_armed_reg <= armed_next;
            b_seen_reg  <= seen_next;
        end
        if (b_valid_reg && out_free)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `RPDM_ASSERT(a_seen_sticky, !$fell(seen_reg), "odometry seen flag dropped")
    `RPDM_ASSERT(a_disarm_cause, $fell(armed_reg) |-> $past(fire && (q_item.cmd == CMD_REBASE || q_item.cmd == CMD_SAMPLE)), "goal disarmed without rebase")
    `RPDM_ASSERT_NEXT(a_rebase_trig, fire && q_item.cmd == CMD_REBASE, cordic_rsp.busy, "rebase did not start trig unit")
    `RPDM_ASSERT_NEXT(a_stage_hold, b_valid_reg && !out_free, b_valid_reg, "stage B lost a word")

endmodule

// File: rtl/relative_pose_displacement_monitor_core.sv
// Relative pose displacement monitor, top level.
// An accepted word passes the queue slot, the stage A registers and the output register
// before m_axis_tvalid rises.
// Throughput: one word per cycle while m_axis_tready holds; after a rebase (or the first
// sample) the next word waits while the iterative CORDIC forms the start cosine and sine.
// Reset (rst_n low, asynchronous) empties the queue and pipeline, zeroes the pose state,
// sets the start cosine to one and loads tolerances 3277 and 182.
`timescale 1ns / 1ps
module relative_pose_displacement_monitor_core
    import rpdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [79:0]        s_axis_tdata,   // pos_x[31:0], pos_y[63:32], yaw_angle[79:64]
    input  logic [1:0]         s_axis_tuser,   // command
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // disp_x, disp_y, disp_yaw, err_x, err_y, err_yaw (32 bits each from bit 0),
    // then x_within[192], y_within, yaw_within, goal_reached, odometry_ready,
    // goal_armed[197], zero pad to 200
    output logic [199:0]       m_axis_tdata,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LTOL_W-1:0] lin_tol_reg, lin_tol_next;
    logic [ATOL_W-1:0] ang_tol_reg, ang_tol_next;
    logic              cfg_wr;
    logic              q_valid, q_pop;
    item_t             q_item;
    cordic_req_t       cordic_req;
    cordic_rsp_t       cordic_rsp;

    // register file: word-aligned, paddr[2] picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        lin_tol_next = lin_tol_reg;
        ang_tol_next = ang_tol_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_LIN_TOL: lin_tol_next = pwdata[LTOL_W-1:0];
                REG_ANG_TOL: ang_tol_next = pwdata[ATOL_W-1:0];
                default:     lin_tol_next = lin_tol_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_LIN_TOL: prdata = {{(32-LTOL_W){1'b0}}, lin_tol_reg};
            REG_ANG_TOL: prdata = {{(32-ATOL_W){1'b0}}, ang_tol_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_tol_reg <= LTOL_RESET;
            ang_tol_reg <= ATOL_RESET;
        end
        else
        begin
            lin_tol_reg <= lin_tol_next;
            ang_tol_reg <= ang_tol_next;
        end
    end

    // accept and classify words; the queue lets the back end stall on its own
    rpdm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // start-frame trig, recomputed on every rebase
    rpdm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    // pose state, displacement, goal errors and the output register
    rpdm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .cordic_req    (cordic_req),
        .cordic_rsp    (cordic_rsp),
        .lin_tol       (lin_tol_reg),
        .ang_tol       (ang_tol_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
